// File: rtl/stt_pkg.sv
// Shared types, constants and helpers for the search transposition table.
// Depends on nothing; stt_eval, the top level and the testbench import it.
package stt_pkg;

    localparam int IndexBits = 16;
    localparam int TagBits   = 64 - IndexBits;

    localparam logic signed [16:0] MateZone      = 17'sd18000;
    localparam logic [6:0]         MoveDepthMin  = 7'd2;

    localparam logic CMD_PROBE = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    typedef enum logic [1:0] {
        KIND_EXACT = 2'd0,
        KIND_UPPER = 2'd1,
        KIND_LOWER = 2'd2
    } t_kind;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    // One table slot. The low key bits are the slot address, so only the tag is kept.
    typedef struct packed {
        logic                used;
        logic [TagBits-1:0]  tag;
        logic signed [15:0]  value;
        logic [15:0]         move;
        logic [6:0]          depth;
        logic [6:0]          ply;
        t_kind               kind;
    } t_entry;

    localparam int EntryBits = $bits(t_entry);

    // Request fields that travel alongside the memory read.
    typedef struct packed {
        logic                store;
        logic [TagBits-1:0]  tag;
        logic signed [15:0]  alpha;
        logic signed [15:0]  beta;
        logic [6:0]          depth;
        logic [6:0]          ply;
    } t_req;

    typedef struct packed {
        logic                hit;
        logic                value_valid;
        logic signed [16:0]  value;
        logic                move_valid;
        logic [15:0]         best_move;
    } t_result;

    // The alpha test comes first, so in an empty window a value at or below alpha is an upper bound.
    function automatic t_kind f_classify(logic signed [15:0] value,
                                         logic signed [15:0] alpha,
                                         logic signed [15:0] beta);
        t_kind kind;
        if (value <= alpha) begin
            kind = KIND_UPPER;
        end else if (value >= beta) begin
            kind = KIND_LOWER;
        end else begin
            kind = KIND_EXACT;
        end
        return kind;
    endfunction

endpackage

// File: rtl/stt_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing.
module stt_ram #(
    parameter int Width    = 8,
    parameter int AddrBits = 4
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic                i_re,
    input  logic [AddrBits-1:0] i_addr,
    input  logic [Width-1:0]    i_wdata,
    output logic [Width-1:0]    o_rdata
);

    logic [Width-1:0] r_mem [2**AddrBits];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/stt_eval.sv
// Probe evaluation: tag match, depth check, mate score correction and bound test.
// Depends on stt_pkg.
module stt_eval
    import stt_pkg::*;
(
    input  t_entry  i_entry,
    input  t_req    i_req,
    output t_result o_res
);

    logic               w_match;
    logic signed [7:0]  w_diff;
    logic signed [16:0] w_diff_ext;
    logic signed [16:0] w_stored;
    logic signed [16:0] w_corr;
    logic signed [16:0] w_alpha;
    logic signed [16:0] w_beta;
    logic               w_usable;

    always_comb begin
        w_match    = i_entry.used && (i_entry.tag == i_req.tag);
        w_diff     = signed'({1'b0, i_entry.ply}) - signed'({1'b0, i_req.ply});
        w_diff_ext = {{9{w_diff[7]}}, w_diff};
        w_stored   = {i_entry.value[15], i_entry.value};
        w_alpha    = {i_req.alpha[15], i_req.alpha};
        w_beta     = {i_req.beta[15], i_req.beta};

        // Mate scores are stored relative to the storing ply and shifted to this one.
        if (w_stored > MateZone) begin
            w_corr = w_stored + w_diff_ext;
        end else if (w_stored < -MateZone) begin
            w_corr = w_stored - w_diff_ext;
        end else begin
            w_corr = w_stored;
        end

        unique case (i_entry.kind)
            KIND_EXACT: w_usable = 1'b1;
            KIND_UPPER: w_usable = (w_corr <= w_alpha);
            KIND_LOWER: w_usable = (w_corr >= w_beta);
            default:    w_usable = 1'b0;
        endcase

        o_res = '0;
        if (!i_req.store && w_match) begin
            o_res.hit = 1'b1;
            if ((i_entry.depth >= i_req.depth) && w_usable) begin
                o_res.value_valid = 1'b1;
                o_res.value       = w_corr;
            end
            if (i_req.depth > MoveDepthMin) begin
                o_res.move_valid = 1'b1;
                o_res.best_move  = i_entry.move;
            end
        end
    end

endmodule

// File: rtl/search_transposition_table_top.sv
// Top level of the search transposition table: stream ports, clearing pass and pipeline.
// Depends on stt_pkg, stt_ram and stt_eval.
//
// A direct-mapped, always-replace transposition table held in one single-port
// synchronous RAM of 2**IndexBits slots (65536 at the default). After reset the
// block runs a clearing pass that writes one empty slot per cycle, and no beat
// is taken until the pass is done, as tready stays low. Then every input
// beat is either a probe or a store; both give exactly one result beat. A store
// writes its slot in the cycle it is accepted and answers with an all-zero result.
// A probe reads its slot in the cycle it is accepted; stage one checks the read
// data and moves the result into the output register once that register is free.
// The single RAM port does one access per cycle, which sets
// the sustained rate at one beat per cycle while the output side keeps taking
// results; because a store is written before any later probe reads, a probe
// always sees every earlier store without forwarding.
module search_transposition_table_top
    import stt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // Fields from bit 0 up: key[63:0], alpha[79:64], beta[95:80], depth[102:96],
    // ply[109:103], store_value[125:110], store_move[141:126], zero pad[143:142].
    input  logic [143:0] i_s_tdata,
    // Fields from bit 0 up: cmd (0 probe, 1 store).
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // Fields from bit 0 up: hit[0], value_valid[1], value[18:2], move_valid[19],
    // best_move[35:20], zero pad[39:36].
    output logic [39:0]  o_m_tdata
);

    // Input field unpacking.
    logic [63:0]        w_key;
    logic signed [15:0] w_alpha;
    logic signed [15:0] w_beta;
    logic [6:0]         w_depth;
    logic [6:0]         w_ply;
    logic signed [15:0] w_sval;
    logic [15:0]        w_smove;

    assign w_key   = i_s_tdata[63:0];
    assign w_alpha = i_s_tdata[79:64];
    assign w_beta  = i_s_tdata[95:80];
    assign w_depth = i_s_tdata[102:96];
    assign w_ply   = i_s_tdata[109:103];
    assign w_sval  = i_s_tdata[125:110];
    assign w_smove = i_s_tdata[141:126];

    // Control state.
    t_state               r_state, n_state;
    logic [IndexBits-1:0] r_clr_idx, n_clr_idx;
    logic                 w_clearing;
    logic                 r_s1_valid, n_s1_valid;
    logic                 r_out_valid, n_out_valid;

    // Payload registers.
    t_req    r_s1_req;
    t_result r_out_res;

    logic w_s_acc;
    logic w_out_free;
    logic w_ready;

    // RAM port.
    logic                 w_ram_we;
    logic                 w_ram_re;
    logic [IndexBits-1:0] w_ram_addr;
    t_entry               w_new_entry;
    logic [EntryBits-1:0] w_ram_wdata;
    logic [EntryBits-1:0] w_ram_rdata;
    t_entry               w_rd_entry;
    t_result              w_eval_res;

    // Clearing pass state machine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_idx  = r_clr_idx;
        w_clearing = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_clearing = 1'b1;
                n_clr_idx  = r_clr_idx + 1'b1;
                if (r_clr_idx == '1) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                w_clearing = 1'b0;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Handshake. The output register frees up whenever it is empty or being taken;
    // stage one waits for it, and the input waits for stage one.
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_ready    = !w_clearing && (!r_s1_valid || w_out_free);
    assign w_s_acc    = i_s_tvalid && w_ready;
    assign o_s_tready = w_ready;

    // RAM access: clearing writes, store writes, probe reads. A read only happens on
    // an accepted probe, so the read data holds while stage one is stalled.
    always_comb begin
        w_new_entry.used  = 1'b1;
        w_new_entry.tag   = w_key[63:IndexBits];
        w_new_entry.value = w_sval;
        w_new_entry.move  = w_smove;
        w_new_entry.depth = w_depth;
        w_new_entry.ply   = w_ply;
        w_new_entry.kind  = f_classify(w_sval, w_alpha, w_beta);
    end

    assign w_ram_we    = w_clearing || (w_s_acc && (i_s_tuser == CMD_STORE));
    assign w_ram_re    = w_s_acc && (i_s_tuser == CMD_PROBE);
    assign w_ram_addr  = w_clearing ? r_clr_idx : w_key[IndexBits-1:0];
    assign w_ram_wdata = w_clearing ? '0 : w_new_entry;

    stt_ram #(
        .Width    (EntryBits),
        .AddrBits (IndexBits)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_re    (w_ram_re),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    assign w_rd_entry = w_ram_rdata;

    stt_eval u_eval (
        .i_entry (w_rd_entry),
        .i_req   (r_s1_req),
        .o_res   (w_eval_res)
    );

    // Stage one and output register.
    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (w_out_free) begin
            n_out_valid = r_s1_valid;
            n_s1_valid  = 1'b0;
        end
        if (w_s_acc) begin
            n_s1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_s1_req.store <= (i_s_tuser == CMD_STORE);
            r_s1_req.tag   <= w_key[63:IndexBits];
            r_s1_req.alpha <= w_alpha;
            r_s1_req.beta  <= w_beta;
            r_s1_req.depth <= w_depth;
            r_s1_req.ply   <= w_ply;
        end
        if (w_out_free && r_s1_valid) begin
            r_out_res <= w_eval_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_res.best_move, r_out_res.move_valid,
                         r_out_res.value, r_out_res.value_valid, r_out_res.hit};

`ifndef ASSERT_OFF
    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!o_m_tvalid && !r_s1_valid))
        else $error("result pending during clearing pass");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while stage one is stalled");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> r_s1_valid)
        else $error("accepted beat did not reach stage one");

    a_clear_runs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == ST_CLEAR && r_state == ST_RUN) |-> ($past(r_clr_idx) == '1))
        else $error("clearing pass ended early");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !r_out_res.hit) |->
            (!r_out_res.value_valid && !r_out_res.move_valid && r_out_res.value == '0))
        else $error("miss result carries data");
`endif

endmodule

// File: test/tb_search_transposition_table_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the search transposition table top level.
// Depends on stt_pkg and the block's RTL; a scoreboard class predicts and checks every result beat.
module tb_search_transposition_table_top;
    import stt_pkg::*;

    localparam int StallLimit   = 200000;  // idle cycles allowed, covers the clearing pass
    localparam int ItemsPerRun  = 617;     // random beats in each of the three idle profiles
    localparam int HoldCycles   = 400;     // long receiver hold-off in the first profile
    localparam int PoolSize     = 48;

    // One request beat as the sender sees it.
    typedef struct {
        logic               cmd;
        logic [63:0]        key;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic [6:0]         depth;
        logic [6:0]         ply;
        logic signed [15:0] sval;
        logic [15:0]        move;
    } t_request;

    // Mirror of one table slot, with the full key kept for the match.
    typedef struct {
        logic [63:0]        key;
        logic signed [15:0] value;
        logic [15:0]        move;
        logic [6:0]         depth;
        logic [6:0]         ply;
        t_kind              kind;
    } t_slot;

    class t_scoreboard;
        t_slot    slot_table[int];       // only slots written since reset exist
        t_result  awaited_results[$];
        int       mismatches;
        int       results_checked;
        int       hits_expected;

        function new();
            mismatches = 0;
            results_checked = 0;
            hits_expected = 0;
        endfunction

        // Applies one request to the mirrored table and returns the result it must produce.
        function t_result table_access(t_request rq);
            t_result  res;
            t_slot    ent;
            int       slot;
            int       score;
            res  = '0;
            slot = int'(rq.key[IndexBits-1:0]);
            if (rq.cmd == CMD_STORE) begin
                ent.key   = rq.key;
                ent.value = rq.sval;
                ent.move  = rq.move;
                ent.depth = rq.depth;
                ent.ply   = rq.ply;
                // The alpha test wins when the window is empty.
                if (rq.sval <= rq.alpha) begin
                    ent.kind = KIND_UPPER;
                end else if (rq.sval >= rq.beta) begin
                    ent.kind = KIND_LOWER;
                end else begin
                    ent.kind = KIND_EXACT;
                end
                slot_table[slot] = ent;
            end else if (slot_table.exists(slot) && slot_table[slot].key == rq.key) begin
                ent = slot_table[slot];
                res.hit = 1'b1;
                hits_expected++;
                if (ent.depth >= rq.depth) begin
                    score = int'(ent.value);
                    // Mate scores are moved by the difference between probe and store ply.
                    if (score > int'(MateZone)) begin
                        score = score - int'(rq.ply) + int'(ent.ply);
                    end else if (score < -int'(MateZone)) begin
                        score = score + int'(rq.ply) - int'(ent.ply);
                    end
                    case (ent.kind)
                        KIND_EXACT: res.value_valid = 1'b1;
                        KIND_UPPER: res.value_valid = (score <= int'(rq.alpha));
                        KIND_LOWER: res.value_valid = (score >= int'(rq.beta));
                        default:    res.value_valid = 1'b0;
                    endcase
                    if (res.value_valid) begin
                        res.value = score[16:0];
                    end
                end
                if (rq.depth > MoveDepthMin) begin
                    res.move_valid = 1'b1;
                    res.best_move  = ent.move;
                end
            end
            return res;
        endfunction

        function void note_input(t_request rq);
            awaited_results = {awaited_results, table_access(rq)};
        endfunction

        function void check_result(logic [39:0] beat);
            t_result got;
            t_result exp;
            got.hit         = beat[0];
            got.value_valid = beat[1];
            got.value       = beat[18:2];
            got.move_valid  = beat[19];
            got.best_move   = beat[35:20];
            results_checked++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat: hit=%0d vv=%0d value=%0d mv=%0d move=%h",
                         $time, got.hit, got.value_valid, got.value, got.move_valid,
                         got.best_move);
            end else begin
                exp = awaited_results.pop_front();
                if (got !== exp) begin
                    mismatches++;
                    $display("%0t: mismatch, expected hit=%0d vv=%0d value=%0d mv=%0d move=%h",
                             $time, exp.hit, exp.value_valid, exp.value, exp.move_valid,
                             exp.best_move);
                    $display("%0t:            actual hit=%0d vv=%0d value=%0d mv=%0d move=%h",
                             $time, got.hit, got.value_valid, got.value, got.move_valid,
                             got.best_move);
                end
            end
        endfunction
    endclass

    // Block ports. Every input starts at a known value.
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    // Fields from bit 0 up: key, alpha, beta, depth, ply, store_value, store_move, zero pad.
    logic [143:0] i_s_tdata = '0;
    // Fields from bit 0 up: cmd.
    logic         i_s_tuser = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    // Fields from bit 0 up: hit, value_valid, value, move_valid, best_move, zero pad.
    logic [39:0]  o_m_tdata;

    search_transposition_table_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    t_scoreboard sb = new();

    // Idle profile of both sides: percent of cycles in which each side idles.
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_request = 1'b0;
    int  beats_sent = 0;

    // Keys reused by the random part so probes find what was stored. The upper half
    // shares slots with the lower half but carries other tags, so slots get stolen.
    logic [63:0] key_pool[PoolSize];
    int          pool_score[PoolSize];

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < StallLimit) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no beat accepted for %0d cycles", $time, StallLimit);
        $display("Verification failed");
        $finish;
    end

    // Receiver: checks each accepted result beat and decides tready for the next cycle.
    // A hold-off request from the stimulus keeps tready low for a counted stretch.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) begin
                sb.check_result(o_m_tdata);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offers one request beat and returns at the edge that accepts it. The valid is
    // only lowered when an idle gap is taken, so back-to-back beats keep it high.
    task automatic send_request(input t_request rq);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= rq.cmd;
        i_s_tdata  <= {2'b00, rq.move, rq.sval, rq.ply, rq.depth, rq.beta, rq.alpha, rq.key};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(rq);
        beats_sent++;
    endtask

    task automatic issue(input logic cmd, input logic [63:0] key, input int alpha,
                         input int beta, input int depth, input int ply, input int sval,
                         input int move);
        t_request rq;
        rq.cmd   = cmd;
        rq.key   = key;
        rq.alpha = alpha[15:0];
        rq.beta  = beta[15:0];
        rq.depth = depth[6:0];
        rq.ply   = ply[6:0];
        rq.sval  = sval[15:0];
        rq.move  = move[15:0];
        send_request(rq);
    endtask

    // Lowers the valid and waits until every awaited result has come back.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (sb.awaited_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] clamp16(input int v);
        int c;
        c = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
        return c[15:0];
    endfunction

    // Scores lean toward the mate range and its edges, where the ply correction acts.
    function automatic logic signed [15:0] pick_score();
        int v;
        int edges[7];
        edges = '{18000, 18001, -18000, -18001, 32767, -32768, 0};
        case ($urandom_range(9))
            0:       v = 18001 + $urandom_range(0, 14766);
            1:       v = -18001 - $urandom_range(0, 14767);
            2:       v = edges[$urandom_range(6)];
            3, 4:    v = int'($signed(16'($urandom)));
            default: v = int'($urandom_range(0, 2000)) - 1000;
        endcase
        return v[15:0];
    endfunction

    // Builds a random request: mostly pool keys with windows near the stored score,
    // some fresh keys that land on empty or foreign slots, some fully random windows.
    task automatic make_random(output t_request rq);
        int idx;
        int center;
        rq.cmd = ($urandom_range(99) < 45) ? CMD_STORE : CMD_PROBE;
        if ($urandom_range(99) < 85) begin
            idx = $urandom_range(PoolSize - 1);
            rq.key = key_pool[idx];
        end else begin
            idx = -1;
            rq.key = {$urandom, $urandom};
        end
        rq.sval  = pick_score();
        rq.move  = 16'($urandom);
        rq.depth = $urandom_range(1) ? 7'($urandom_range(0, 6)) : 7'($urandom_range(0, 127));
        rq.ply   = 7'($urandom_range(0, 127));
        if (rq.cmd == CMD_STORE || idx < 0) begin
            center = int'(rq.sval);
        end else begin
            center = pool_score[idx];
        end
        if (rq.cmd == CMD_STORE && idx >= 0) begin
            pool_score[idx] = int'(rq.sval);
        end
        if ($urandom_range(99) < 20) begin
            rq.alpha = 16'($urandom);
            rq.beta  = 16'($urandom);
        end else begin
            rq.alpha = clamp16(center + int'($urandom_range(0, 400)) - 200);
            rq.beta  = clamp16(center + int'($urandom_range(0, 400)) - 200);
        end
    endtask

    // Main stimulus: reset, directed cases, then three idle profiles of random traffic.
    initial begin
        t_request    rq;
        int          directed_count;
        for (int i = 0; i < PoolSize / 2; i++) begin
            key_pool[i] = {$urandom, $urandom};
            key_pool[i + PoolSize / 2] = {$urandom, 16'($urandom), key_pool[i][15:0]};
            pool_score[i] = 0;
            pool_score[i + PoolSize / 2] = 0;
        end

        // Synchronous reset held once at the start. The block then clears its
        // table and keeps tready low until that pass is done; the first beat waits on it.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A zero key into a never-written slot must miss.
        issue(CMD_PROBE, 64'h0, 0, 0, 5, 0, 0, 0);
        // Exact entry, then probes for a full hit, too little stored depth, and a
        // requested depth too shallow to return the move.
        issue(CMD_STORE, 64'h0123_4567_89ab_cdef, -100, 100, 10, 5, 42, 16'hffff);
        issue(CMD_PROBE, 64'h0123_4567_89ab_cdef, -100, 100, 10, 0, 0, 0);
        issue(CMD_PROBE, 64'h0123_4567_89ab_cdef, -100, 100, 11, 0, 0, 0);
        issue(CMD_PROBE, 64'h0123_4567_89ab_cdef, -100, 100, 2, 0, 0, 0);
        // Same slot, different tag: a miss.
        issue(CMD_PROBE, 64'hfedc_ba98_7654_cdef, -100, 100, 10, 0, 0, 0);
        // Top score as a lower bound at the all-ones key, corrected down by full ply.
        issue(CMD_STORE, 64'hffff_ffff_ffff_ffff, -32768, 32767, 127, 0, 32767, 0);
        issue(CMD_PROBE, 64'hffff_ffff_ffff_ffff, 0, -32768, 127, 127, 0, 0);
        issue(CMD_PROBE, 64'hffff_ffff_ffff_ffff, 0, 32767, 127, 127, 0, 0);
        // Always-replace: the other tag takes the slot with the lowest score as an
        // upper bound; the old key now misses.
        issue(CMD_STORE, 64'hfedc_ba98_7654_cdef, -32768, 0, 127, 127, -32768, 16'h8001);
        issue(CMD_PROBE, 64'hfedc_ba98_7654_cdef, 32767, 0, 127, 0, 0, 0);
        issue(CMD_PROBE, 64'h0123_4567_89ab_cdef, 32767, 0, 127, 0, 0, 0);
        // Empty window with the value on alpha classifies as an upper bound; 18000
        // itself is outside the mate range and stays uncorrected.
        issue(CMD_STORE, 64'h0000_0000_0000_0001, 18000, 18000, 5, 100, 18000, 16'h0001);
        issue(CMD_PROBE, 64'h0000_0000_0000_0001, 18000, 18000, 5, 0, 0, 0);
        issue(CMD_PROBE, 64'h0000_0000_0000_0001, 17999, 18000, 5, 0, 0, 0);
        // Just inside the mate range as a lower bound, corrected up by the ply gap.
        issue(CMD_STORE, 64'h8000_0000_0000_0002, -32768, -32768, 0, 10, 18001, 16'h1234);
        issue(CMD_PROBE, 64'h8000_0000_0000_0002, -32768, 18008, 0, 3, 0, 0);
        issue(CMD_PROBE, 64'h8000_0000_0000_0002, -32768, 18009, 0, 3, 0, 0);
        // Negative mate bound as exact, and -18000 left alone.
        issue(CMD_STORE, 64'h7fff_ffff_ffff_0003, -32768, 32767, 3, 0, -18001, 16'h5a5a);
        issue(CMD_PROBE, 64'h7fff_ffff_ffff_0003, -32768, 32767, 3, 7, 0, 0);
        issue(CMD_STORE, 64'h0000_0000_0000_0004, -32768, 32767, 9, 50, -18000, 16'ha5a5);
        issue(CMD_PROBE, 64'h0000_0000_0000_0004, -32768, 32767, 9, 0, 0, 0);
        // Highest score at the deepest ply, read back from the root: widest result.
        issue(CMD_STORE, 64'h5555_aaaa_5555_0005, -32768, 32767, 127, 127, 32767, 16'h7fff);
        issue(CMD_PROBE, 64'h5555_aaaa_5555_0005, -32768, 32767, 127, 0, 0, 0);
        directed_count = beats_sent;
        drain_results();

        // Random part in three idle profiles. The first opens with a long receiver
        // hold-off so the pipeline fills and the input stalls; after each profile the
        // sender pauses until every awaited result is back.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 86;
                    hold_request = 1'b1;
                end
                1: begin
                    tx_idle_pct = 86;
                    rx_idle_pct = 20;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < ItemsPerRun; n++) begin
                make_random(rq);
                send_request(rq);
            end
            drain_results();
        end

        // Every awaited result is back; keep the clock running so that any stray beat
        // still shows up and is counted as a mismatch.
        repeat (10) @(posedge i_clk);

        $display("Covered %0d request beats (%0d directed) over three idle profiles,",
                 beats_sent, directed_count);
        $display("%0d result beats checked, %0d probe hits, %0d mismatches.",
                 sb.results_checked, sb.hits_expected, sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/stt_pkg.sv
rtl/stt_ram.sv
rtl/stt_eval.sv
rtl/search_transposition_table_top.sv
test/tb_search_transposition_table_top.sv
